>>> design/scp_pkg.sv
// scp_pkg: shared constants, types and helper functions of the scope column peak hold
// used by the interfaces, the datapath, the divider, the controller and the top level
package scp_pkg;

    localparam int MAX_COLUMNS   = 64;
    localparam int FRAME_SAMPLES = 256;

    localparam int COL_W      = $clog2(MAX_COLUMNS);
    localparam int CNT_W      = COL_W + 1;
    localparam int POS_W      = $clog2(FRAME_SAMPLES) + 1;
    localparam int SMP_W      = 16;
    localparam int SUM_W      = SMP_W + 1;
    localparam int HH_W       = 11;
    localparam int FALL_W     = 24;
    localparam int MAG_W      = 28;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_STEPS  = POS_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int REM_W      = CNT_W + 1;

    localparam logic [FALL_W-1:0] EMPTY_DECAY      = FALL_W'(131072);
    localparam logic [FALL_W-1:0] RST_FALLOFF      = FALL_W'(65536);
    localparam logic [HH_W-1:0]   RST_HALF_HEIGHT  = HH_W'(128);
    localparam logic [CNT_W-1:0]  RST_COLUMN_COUNT = CNT_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUBBERBAND   = 2'd0,
        CFG_FALLOFF      = 2'd1,
        CFG_HALF_HEIGHT  = 2'd2,
        CFG_COLUMN_COUNT = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL,
        S_FOLD,
        S_WAIT,
        S_EMIT,
        S_START,
        S_AFTER,
        S_FLUSH,
        S_RESTART,
        S_RSTART,
        S_ERD,
        S_EWR
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic mul;
        logic fold;
        logic div_go;
        logic emit;
        logic start;
        logic restart;
        logic clr_cnt;
        logic erd;
        logic ewrite;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic func;
        logic frame_end;
        logic cur_lt_n;
        logic nxt_lt_n;
        logic pos_lt_frame;
        logic at_bound;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic logic [CNT_W-1:0] active_columns(input logic [CNT_W-1:0] cc);
        logic [CNT_W-1:0] n;
        n = cc;
        if (cc == '0) n = CNT_W'(1);
        else if (cc > CNT_W'(MAX_COLUMNS)) n = CNT_W'(MAX_COLUMNS);
        return n;
    endfunction

    function automatic logic signed [MAG_W-1:0] decay_to_zero(
        input logic signed [MAG_W-1:0] v,
        input logic [FALL_W-1:0]       d
    );
        logic signed [MAG_W:0] dx;
        logic signed [MAG_W:0] t;
        dx = $signed({{(MAG_W-FALL_W+1){1'b0}}, d});
        if (v < 0) begin
            t = {v[MAG_W-1], v} + dx;
            if (t > 0) t = '0;
        end else begin
            t = {v[MAG_W-1], v} - dx;
            if (t < 0) t = '0;
        end
        return t[MAG_W-1:0];
    endfunction

endpackage

>>> design/scp_intf.sv
// scp_intf: sample, column result and configuration channel interfaces
// depends on scp_pkg for field widths
interface scp_smp_if import scp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic signed [SMP_W-1:0] left_sample;
    logic signed [SMP_W-1:0] right_sample;
    logic                    frame_end;

    modport source(output valid, func, left_sample, right_sample, frame_end, input ready);
    modport sink(input valid, func, left_sample, right_sample, frame_end, output ready);
endinterface

interface scp_col_if import scp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [COL_W-1:0]        column;
    logic signed [MAG_W-1:0] magnitude;
    logic                    last;
    logic                    all_zero;

    modport source(output valid, column, magnitude, last, all_zero, input ready);
    modport sink(input valid, column, magnitude, last, all_zero, output ready);
endinterface

interface scp_cfg_if import scp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

>>> design/scope_column_peak_hold.sv
// scope_column_peak_hold: audio scope column decimator with peak hold, top level
// a sample passes dispatch, multiply, fold and the divide wait; each column it closes adds
// (emit, start value read except for the last column, 9 step divide for the next column end)
// frame end: flush, emit, start, after per open column; empty frame: read, write per column
// results sit in an output register and appear in the cycle after their emit step
// reset: synchronous active low; clears control state and the per-column valid bits
module scope_column_peak_hold import scp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scp_cfg_if.sink   i_cfg,
    scp_smp_if.sink   i_smp,
    scp_col_if.source o_col
);
    t_cmd cmd;
    t_sts sts;

    scp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    scp_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_smp   (i_smp),
        .o_col   (o_col),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );
endmodule

>>> design/scp_ram.sv
// scp_ram: generic single write port, single read port memory with registered read
// no dependencies
module scp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/scp_div.sv
// scp_div: serial divider for the column end, (column+1)*FRAME_SAMPLES / column count
// one quotient bit per cycle; depends on scp_pkg
module scp_div import scp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [REM_W-1:0] i_num,
    input  logic [CNT_W-1:0] i_den,
    output logic [POS_W-1:0] o_quo,
    output logic             o_done
);
    logic [REM_W-1:0]     r_rem;
    logic [POS_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 ge;
    logic [REM_W-1:0]     diff;

    assign ge   = r_rem >= {1'b0, i_den};
    assign diff = ge ? r_rem - {1'b0, i_den} : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_go) begin
            r_cnt <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= i_num;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= {diff[REM_W-2:0], 1'b0};
            r_quo <= {r_quo[POS_W-2:0], ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = (r_cnt == '0);
endmodule

>>> design/scp_dpath.sv
// scp_dpath: registers, scaler, extreme fold, column memory and output register
// depends on scp_pkg, scp_intf, scp_ram and scp_div
module scp_dpath import scp_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    scp_cfg_if.sink        i_cfg,
    scp_smp_if.sink        i_smp,
    scp_col_if.source      o_col,
    input  t_cmd           i_cmd,
    output t_sts           o_sts
);
    logic                    r_rb;
    logic [FALL_W-1:0]       r_fall;
    logic [HH_W-1:0]         r_hh;
    logic [CNT_W-1:0]        r_cc;
    logic [CNT_W-1:0]        r_cur;
    logic [POS_W-1:0]        r_pos;
    logic                    r_nz;
    logic signed [MAG_W-1:0] r_ext;
    logic                    r_func;
    logic                    r_fe;
    logic signed [SMP_W-1:0] r_l;
    logic signed [SMP_W-1:0] r_r;
    logic signed [MAG_W-1:0] r_prod;
    logic [MAX_COLUMNS-1:0]  r_vld;
    logic                    r_rd_vld;
    logic                    r_o_valid;
    logic [COL_W-1:0]        r_o_col;
    logic signed [MAG_W-1:0] r_o_mag;
    logic                    r_o_last;
    logic                    r_o_allz;

    logic [CNT_W-1:0]              n_cols;
    logic [CNT_W:0]                cur_inc;
    logic signed [SUM_W-1:0]       smp_sum;
    logic signed [SUM_W+HH_W:0]    prod_full;
    logic signed [MAG_W-1:0]       fold_val;
    logic signed [MAG_W-1:0]       mem_q;
    logic signed [MAG_W-1:0]       rd_val;
    logic signed [MAG_W-1:0]       start_val;
    logic signed [MAG_W-1:0]       empty_val;
    logic signed [MAG_W-1:0]       mag_src;
    logic                          out_last;
    logic                          out_load;
    logic                          out_free;
    logic                          acc;
    logic                          rd_en;
    logic [COL_W-1:0]              rd_addr;
    logic                          wr_en;
    logic [POS_W-1:0]              quo;
    logic                          div_done;

    assign n_cols  = active_columns(r_cc);
    assign cur_inc = {1'b0, r_cur} + (CNT_W+1)'(1);

    assign acc         = i_smp.valid & i_smp.ready;
    assign i_smp.ready = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    // sample scaling and extreme fold
    assign smp_sum   = SUM_W'(r_l) + SUM_W'(r_r);
    assign prod_full = smp_sum * $signed({1'b0, r_hh});

    always_comb begin
        fold_val = r_ext;
        if (r_prod > 0) begin
            if (r_prod > r_ext) fold_val = r_prod;
        end else begin
            if (r_prod < r_ext) fold_val = r_prod;
        end
    end

    // column memory, entries never written read as zero
    assign rd_en   = i_cmd.emit | i_cmd.restart | i_cmd.erd;
    assign rd_addr = i_cmd.restart ? '0 : (i_cmd.emit ? cur_inc[COL_W-1:0] : r_cur[COL_W-1:0]);
    assign wr_en   = i_cmd.emit | i_cmd.ewrite;
    assign rd_val  = r_rd_vld ? mem_q : '0;

    assign start_val = r_rb ? decay_to_zero(rd_val, r_fall) : '0;
    assign empty_val = r_rb ? decay_to_zero(rd_val, EMPTY_DECAY) : '0;
    assign mag_src   = i_cmd.emit ? r_ext : empty_val;
    assign out_last  = (cur_inc == {1'b0, n_cols});

    scp_ram #(
        .WIDTH (MAG_W),
        .DEPTH (MAX_COLUMNS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_cur[COL_W-1:0]),
        .i_wdata (mag_src),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (mem_q)
    );

    scp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (cur_inc),
        .i_den   (n_cols),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    assign out_free = ~r_o_valid | o_col.ready;
    assign out_load = wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rb      <= 1'b0;
            r_fall    <= RST_FALLOFF;
            r_hh      <= RST_HALF_HEIGHT;
            r_cc      <= RST_COLUMN_COUNT;
            r_cur     <= '0;
            r_pos     <= '0;
            r_nz      <= 1'b0;
            r_ext     <= '0;
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_RUBBERBAND:   r_rb   <= i_cfg.data[0];
                    CFG_FALLOFF:      r_fall <= i_cfg.data[FALL_W-1:0];
                    CFG_HALF_HEIGHT:  r_hh   <= i_cfg.data[HH_W-1:0];
                    CFG_COLUMN_COUNT: r_cc   <= i_cfg.data[CNT_W-1:0];
                endcase
            end
            if (i_cmd.mul) begin
                r_pos <= r_pos + POS_W'(1);
            end
            if (i_cmd.fold) begin
                r_ext <= fold_val;
            end
            if (i_cmd.start) begin
                r_ext <= start_val;
            end
            if (i_cmd.clr_cnt) begin
                r_cur <= '0;
                r_nz  <= 1'b0;
            end
            if (i_cmd.restart) begin
                r_cur <= '0;
                r_pos <= '0;
                r_nz  <= 1'b0;
            end
            if (wr_en) begin
                r_cur                    <= cur_inc[CNT_W-1:0];
                r_nz                     <= r_nz | (mag_src != '0);
                r_vld[r_cur[COL_W-1:0]] <= 1'b1;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_col.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_func <= i_smp.func;
            r_fe   <= i_smp.frame_end;
            r_l    <= i_smp.left_sample;
            r_r    <= i_smp.right_sample;
        end
        if (i_cmd.mul) begin
            r_prod <= prod_full[MAG_W-1:0];
        end
        if (rd_en) begin
            r_rd_vld <= r_vld[rd_addr];
        end
        if (out_load) begin
            r_o_col  <= r_cur[COL_W-1:0];
            r_o_mag  <= mag_src;
            r_o_last <= out_last;
            r_o_allz <= out_last & ~(r_nz | (mag_src != '0));
        end
    end

    assign o_col.valid     = r_o_valid;
    assign o_col.column    = r_o_col;
    assign o_col.magnitude = r_o_mag;
    assign o_col.last      = r_o_last;
    assign o_col.all_zero  = r_o_allz;

    always_comb begin
        o_sts              = '0;
        o_sts.in_valid     = i_smp.valid;
        o_sts.func         = r_func;
        o_sts.frame_end    = r_fe;
        o_sts.cur_lt_n     = r_cur < n_cols;
        o_sts.nxt_lt_n     = cur_inc < {1'b0, n_cols};
        o_sts.pos_lt_frame = r_pos < POS_W'(FRAME_SAMPLES);
        o_sts.at_bound     = r_pos >= quo;
        o_sts.div_done     = div_done;
        o_sts.out_free     = out_free;
    end

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.ewrite) |-> out_free)
        else $error("result loaded while output register is occupied");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_go |-> div_done)
        else $error("divider restarted while busy");
    a_mul_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul |-> (r_cur < n_cols && r_pos < POS_W'(FRAME_SAMPLES)))
        else $error("sample folded outside the frame");
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= CNT_W'(MAX_COLUMNS))
        else $error("column index past the last column");
`endif
endmodule

>>> design/scp_ctrl.sv
// scp_ctrl: sequencer for sample, column emit, frame flush and empty frame handling
// depends on scp_pkg
module scp_ctrl import scp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_sts.func) begin
                    o_cmd.clr_cnt = 1'b1;
                    n_state       = S_ERD;
                end else if (i_sts.cur_lt_n && i_sts.pos_lt_frame) begin
                    n_state = S_MUL;
                end else if (i_sts.frame_end) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul    = 1'b1;
                o_cmd.div_go = 1'b1;
                n_state      = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.div_done) begin
                    if (i_sts.cur_lt_n && i_sts.at_bound) n_state = S_EMIT;
                    else if (i_sts.frame_end) n_state = S_FLUSH;
                    else n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.nxt_lt_n ? S_START : S_AFTER;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = S_AFTER;
            end
            S_AFTER: begin
                if (i_sts.frame_end) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.div_go = 1'b1;
                    n_state      = S_WAIT;
                end
            end
            S_FLUSH: begin
                n_state = i_sts.cur_lt_n ? S_EMIT : S_RESTART;
            end
            S_RESTART: begin
                o_cmd.restart = 1'b1;
                n_state       = S_RSTART;
            end
            S_RSTART: begin
                o_cmd.start = 1'b1;
                n_state     = S_IDLE;
            end
            S_ERD: begin
                o_cmd.erd = 1'b1;
                n_state   = S_EWR;
            end
            S_EWR: begin
                if (i_sts.out_free) begin
                    o_cmd.ewrite = 1'b1;
                    n_state      = i_sts.nxt_lt_n ? S_ERD : S_RESTART;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
